// ===== design/rs_pkg.sv =====
// ----------------------------------------------------------------------------
// rs_pkg
// Shared codes for the rectangle subtract block: register indexes of the
// configuration port and the side codes carried by each output piece.
// ----------------------------------------------------------------------------
package rs_pkg;

    localparam int unsigned CFG_IDX_BITS = 2;
    localparam int unsigned SIDE_BITS    = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CUT_X      = 2'd0,
        REG_CUT_Y      = 2'd1,
        REG_CUT_WIDTH  = 2'd2,
        REG_CUT_HEIGHT = 2'd3
    } t_cfg_reg;

    localparam logic [SIDE_BITS-1:0] SIDE_WHOLE  = 3'd0;
    localparam logic [SIDE_BITS-1:0] SIDE_TOP    = 3'd1;
    localparam logic [SIDE_BITS-1:0] SIDE_BOTTOM = 3'd2;
    localparam logic [SIDE_BITS-1:0] SIDE_LEFT   = 3'd3;
    localparam logic [SIDE_BITS-1:0] SIDE_RIGHT  = 3'd4;

endpackage

// ===== design/rs_if.sv =====
// ----------------------------------------------------------------------------
// rs_if
// Valid/ready channels of the rectangle subtract block: input rectangles,
// configuration writes and output pieces.
// ----------------------------------------------------------------------------
interface rs_rect_if #(
    parameter int unsigned COORD_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] rect_x;
    logic [COORD_BITS-1:0] rect_y;
    logic [COORD_BITS-1:0] rect_width;
    logic [COORD_BITS-1:0] rect_height;

    modport source (output valid, rect_x, rect_y, rect_width, rect_height, input ready);
    modport sink   (input valid, rect_x, rect_y, rect_width, rect_height, output ready);
endinterface

interface rs_cfg_if #(
    parameter int unsigned COORD_BITS = 16
);
    logic                            valid;
    logic                            ready;
    logic [rs_pkg::CFG_IDX_BITS-1:0] index;
    logic [COORD_BITS-1:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface rs_piece_if #(
    parameter int unsigned COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [COORD_BITS-1:0]        piece_x;
    logic [COORD_BITS-1:0]        piece_y;
    logic [COORD_BITS-1:0]        piece_width;
    logic [COORD_BITS-1:0]        piece_height;
    logic [rs_pkg::SIDE_BITS-1:0] piece_side;
    logic                         last_piece;

    modport source (output valid, piece_x, piece_y, piece_width, piece_height,
                    piece_side, last_piece, input ready);
    modport sink   (input valid, piece_x, piece_y, piece_width, piece_height,
                    piece_side, last_piece, output ready);
endinterface

// ===== design/rs_serial.sv =====
// ----------------------------------------------------------------------------
// rs_serial
// Piece serialiser: holds the up to four pieces of one item and sends them
// one per cycle while the output is ready, lowest slot first, marking the final one as last.
// ----------------------------------------------------------------------------
module rs_serial #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [3:0]                   i_mask,
    input  logic [COORD_BITS-1:0]        i_x      [4],
    input  logic [COORD_BITS-1:0]        i_y      [4],
    input  logic [COORD_BITS-1:0]        i_width  [4],
    input  logic [COORD_BITS-1:0]        i_height [4],
    input  logic [rs_pkg::SIDE_BITS-1:0] i_side   [4],
    output logic                         o_free,
    rs_piece_if.source                   o_piece
);
    import rs_pkg::*;

    logic [3:0]            r_mask;
    logic [COORD_BITS-1:0] r_x      [4];
    logic [COORD_BITS-1:0] r_y      [4];
    logic [COORD_BITS-1:0] r_width  [4];
    logic [COORD_BITS-1:0] r_height [4];
    logic [SIDE_BITS-1:0]  r_side   [4];

    logic [1:0] sel;
    logic [3:0] n_mask;
    logic       last;
    logic       accept;

    always_comb begin
        priority if (r_mask[0]) begin
            sel = 2'd0;
        end else if (r_mask[1]) begin
            sel = 2'd1;
        end else if (r_mask[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
    end

    assign n_mask = r_mask & ~(4'b0001 << sel);
    assign last   = (n_mask == 4'b0000);
    assign accept = o_piece.valid && o_piece.ready;
    assign o_free = (r_mask == 4'b0000) || (accept && last);

    assign o_piece.valid        = (r_mask != 4'b0000);
    assign o_piece.piece_x      = r_x[sel];
    assign o_piece.piece_y      = r_y[sel];
    assign o_piece.piece_width  = r_width[sel];
    assign o_piece.piece_height = r_height[sel];
    assign o_piece.piece_side   = r_side[sel];
    assign o_piece.last_piece   = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= 4'b0000;
        end else if (i_load) begin
            r_mask <= i_mask;
        end else if (accept) begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x      <= i_x;
            r_y      <= i_y;
            r_width  <= i_width;
            r_height <= i_height;
            r_side   <= i_side;
        end
    end

endmodule

// ===== design/rectangle_subtract.sv =====
// ----------------------------------------------------------------------------
// rectangle_subtract
// Removes the configured cut rectangle from each input rectangle and sends
// the remaining pieces: top, bottom, left, right, the whole input, or none.
// ----------------------------------------------------------------------------
// An input rectangle enters a three-stage pipeline (edge sums, comparisons,
// extents) and moves on through the stage registers to the piece serialiser.
// The output channel carries one piece per cycle while it is ready, so an
// item holds the serialiser until its last piece is taken; an item with no
// pieces does not hold it. Sustained throughput is set by the single output
// port. Input is taken every cycle while the pipeline can move.
// The cut registers must only be written while no item is in flight.
module rectangle_subtract #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rs_rect_if.sink    i_rect,
    rs_cfg_if.sink     i_cfg,
    rs_piece_if.source o_piece
);
    import rs_pkg::*;

    localparam int unsigned W = COORD_BITS;
    localparam int unsigned E = COORD_BITS + 1;

    logic [W-1:0] r_cut_x, r_cut_y, r_cut_w, r_cut_h;

    // stage 1: edge sums
    logic         r_v1;
    logic [W-1:0] r1_rx, r1_ry, r1_rw, r1_rh;
    logic [E-1:0] r1_rright, r1_rbot, r1_cright, r1_cbot;

    // stage 2: comparisons
    logic         r_v2;
    logic [W-1:0] r2_rx, r2_ry, r2_rw, r2_rh;
    logic [E-1:0] r2_rright, r2_rbot, r2_cright, r2_cbot;
    logic         r2_contain, r2_nolap, r2_top, r2_bot, r2_left, r2_right;
    logic [W-1:0] r2_ytop;
    logic [E-1:0] r2_ybot;

    // stage 3: pieces
    logic           r_v3;
    logic [3:0]     r3_mask;
    logic [W-1:0]   r3_x [4];
    logic [W-1:0]   r3_y [4];
    logic [W-1:0]   r3_w [4];
    logic [W-1:0]   r3_h [4];
    logic [SIDE_BITS-1:0] r3_side [4];

    logic ld1, ld2, ld3, ser_free, ser_load;

    logic [3:0]   n_mask;
    logic [W-1:0] n_x [4];
    logic [W-1:0] n_y [4];
    logic [W-1:0] n_w [4];
    logic [W-1:0] n_h [4];
    logic [SIDE_BITS-1:0] n_side [4];
    logic [E-1:0] side_diff;
    logic         side_pos;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_x <= '0;
            r_cut_y <= '0;
            r_cut_w <= '0;
            r_cut_h <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_CUT_X:      r_cut_x <= i_cfg.data;
                REG_CUT_Y:      r_cut_y <= i_cfg.data;
                REG_CUT_WIDTH:  r_cut_w <= i_cfg.data;
                REG_CUT_HEIGHT: r_cut_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign ser_load    = r_v3 && ser_free;
    assign ld3         = !r_v3 || ser_free;
    assign ld2         = !r_v2 || ld3;
    assign ld1         = !r_v1 || ld2;
    assign i_rect.ready = ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld1) begin
                r_v1 <= i_rect.valid;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r1_rx     <= i_rect.rect_x;
            r1_ry     <= i_rect.rect_y;
            r1_rw     <= i_rect.rect_width;
            r1_rh     <= i_rect.rect_height;
            r1_rright <= {1'b0, i_rect.rect_x} + {1'b0, i_rect.rect_width};
            r1_rbot   <= {1'b0, i_rect.rect_y} + {1'b0, i_rect.rect_height};
            r1_cright <= {1'b0, r_cut_x} + {1'b0, r_cut_w};
            r1_cbot   <= {1'b0, r_cut_y} + {1'b0, r_cut_h};
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r2_rx      <= r1_rx;
            r2_ry      <= r1_ry;
            r2_rw      <= r1_rw;
            r2_rh      <= r1_rh;
            r2_rright  <= r1_rright;
            r2_rbot    <= r1_rbot;
            r2_cright  <= r1_cright;
            r2_cbot    <= r1_cbot;
            r2_contain <= (r1_rx >= r_cut_x) && (r1_ry >= r_cut_y)
                          && (r1_rright <= r1_cright) && (r1_rbot <= r1_cbot);
            r2_nolap   <= (r1_rright <= {1'b0, r_cut_x}) || (r1_rbot <= {1'b0, r_cut_y})
                          || ({1'b0, r1_rx} >= r1_cright) || ({1'b0, r1_ry} >= r1_cbot);
            r2_top     <= (r_cut_y > r1_ry);
            r2_bot     <= (r1_rbot > r1_cbot);
            r2_left    <= (r_cut_x > r1_rx);
            r2_right   <= (r1_rright > r1_cright);
            r2_ytop    <= (r_cut_y > r1_ry) ? r_cut_y : r1_ry;
            r2_ybot    <= (r1_cbot < r1_rbot) ? r1_cbot : r1_rbot;
        end
    end

    assign side_diff = r2_ybot - {1'b0, r2_ytop};
    assign side_pos  = (r2_ybot > {1'b0, r2_ytop});

    always_comb begin
        n_x[1]    = r2_rx;
        n_y[1]    = r2_cbot[W-1:0];
        n_w[1]    = r2_rw;
        n_h[1]    = W'(r2_rbot - r2_cbot);
        n_side[1] = SIDE_BOTTOM;
        n_x[2]    = r2_rx;
        n_y[2]    = r2_ytop;
        n_w[2]    = r_cut_x - r2_rx;
        n_h[2]    = side_diff[W-1:0];
        n_side[2] = SIDE_LEFT;
        n_x[3]    = r2_cright[W-1:0];
        n_y[3]    = r2_ytop;
        n_w[3]    = W'(r2_rright - r2_cright);
        n_h[3]    = side_diff[W-1:0];
        n_side[3] = SIDE_RIGHT;
        n_x[0]    = r2_rx;
        n_y[0]    = r2_ry;
        n_w[0]    = r2_rw;
        priority if (r2_contain) begin
            n_mask    = 4'b0000;
            n_h[0]    = r2_rh;
            n_side[0] = SIDE_WHOLE;
        end else if (r2_nolap) begin
            n_mask    = 4'b0001;
            n_h[0]    = r2_rh;
            n_side[0] = SIDE_WHOLE;
        end else begin
            n_mask    = {r2_right && side_pos, r2_left && side_pos, r2_bot, r2_top};
            n_h[0]    = r_cut_y - r2_ry;
            n_side[0] = SIDE_TOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld3) begin
            r3_mask <= n_mask;
            r3_x    <= n_x;
            r3_y    <= n_y;
            r3_w    <= n_w;
            r3_h    <= n_h;
            r3_side <= n_side;
        end
    end

    rs_serial #(
        .COORD_BITS (COORD_BITS)
    ) u_rs_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (ser_load),
        .i_mask   (r3_mask),
        .i_x      (r3_x),
        .i_y      (r3_y),
        .i_width  (r3_w),
        .i_height (r3_h),
        .i_side   (r3_side),
        .o_free   (ser_free),
        .o_piece  (o_piece)
    );

endmodule

// ===== design/rs_checker.sv =====
// ----------------------------------------------------------------------------
// rs_checker
// Port-level checks on the piece output of the rectangle subtract block,
// attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module rs_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic [rs_pkg::SIDE_BITS-1:0] i_side,
    input logic                         i_last
);
    import rs_pkg::*;

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> i_valid)
        else $error("piece valid dropped while stalled");

    a_tag_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> ($stable(i_side) && $stable(i_last)))
        else $error("piece side or last changed while stalled");

    a_whole_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_side == SIDE_WHOLE)) |-> i_last)
        else $error("whole input piece not marked last");

    a_right_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_side == SIDE_RIGHT)) |-> i_last)
        else $error("right piece not marked last");

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ready && !i_last) |=> i_valid)
        else $error("item ended without a last piece");

endmodule

bind rectangle_subtract rs_checker u_rs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_piece.valid),
    .i_ready (o_piece.ready),
    .i_side  (o_piece.piece_side),
    .i_last  (o_piece.last_piece)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for rectangle_subtract. Input rectangles are sent against a series
// of cut rectangles. Each accepted input is run through a behavioural model of
// the difference, which queues the pieces it should produce, and every output
// piece is checked field by field against the oldest queued piece. Both sides
// idle at random, and one stretch holds the output off long enough to stall
// the input.
// ----------------------------------------------------------------------------
module tb_top;
    import rs_pkg::*;

    localparam int unsigned COORD_BITS    = 16;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          DRAIN_LIMIT   = 50000;
    localparam int          MAX_REPORTS   = 10;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          PHASE_ITEMS   = 24;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord w;
        t_coord h;
    } t_box;

    typedef struct packed {
        t_coord               x;
        t_coord               y;
        t_coord               w;
        t_coord               h;
        logic [SIDE_BITS-1:0] side;
        logic                 last;
    } t_piece;

    logic i_clk;
    logic i_rst_n;

    rs_rect_if  #(.COORD_BITS(COORD_BITS)) rect_if ();
    rs_cfg_if   #(.COORD_BITS(COORD_BITS)) cfg_if ();
    rs_piece_if #(.COORD_BITS(COORD_BITS)) piece_if ();

    rectangle_subtract #(.COORD_BITS(COORD_BITS)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rect  (rect_if),
        .i_cfg   (cfg_if),
        .o_piece (piece_if)
    );

    t_box   cut;
    t_piece pending_pieces [$];
    int     mismatch_count = 0;
    int     hold_cycles    = 0;
    bit     holding        = 1'b0;
    bit     tx_gaps_on     = 1'b1;
    bit     rx_stalls_on   = 1'b1;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int gap_len(input bit enabled);
        int roll;
        if (!enabled) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_coord near(input t_coord base, input t_coord extent);
        return t_coord'(base + $urandom_range(0, extent + 64) - 32);
    endfunction

    function automatic t_piece make_piece(input t_coord x, input t_coord y, input t_coord w,
                                          input t_coord h, input logic [SIDE_BITS-1:0] side);
        t_piece p;
        p.x    = x;
        p.y    = y;
        p.w    = w;
        p.h    = h;
        p.side = side;
        p.last = 1'b0;
        return p;
    endfunction

    // Queue the pieces left once the cut is removed from r
    function automatic void subtract_cut(input t_box r);
        logic [COORD_BITS:0] r_right, r_bottom, c_right, c_bottom, y_top, y_bot;
        t_piece              found [$];
        t_piece              p;
        r_right  = {1'b0, r.x} + {1'b0, r.w};
        r_bottom = {1'b0, r.y} + {1'b0, r.h};
        c_right  = {1'b0, cut.x} + {1'b0, cut.w};
        c_bottom = {1'b0, cut.y} + {1'b0, cut.h};
        if (r.x >= cut.x && r.y >= cut.y && r_right <= c_right &&
            r_bottom <= c_bottom) return;
        if (r_right <= cut.x || r_bottom <= cut.y || r.x >= c_right || r.y >= c_bottom) begin
            found.push_back(make_piece(r.x, r.y, r.w, r.h, SIDE_WHOLE));
        end else begin
            if (cut.y > r.y)
                found.push_back(make_piece(r.x, r.y, r.w, cut.y - r.y, SIDE_TOP));
            if (r_bottom > c_bottom)
                found.push_back(make_piece(r.x, c_bottom[COORD_BITS-1:0], r.w,
                                           t_coord'(r_bottom - c_bottom), SIDE_BOTTOM));
            y_top = (cut.y > r.y) ? {1'b0, cut.y} : {1'b0, r.y};
            y_bot = (c_bottom < r_bottom) ? c_bottom : r_bottom;
            if (y_bot > y_top) begin
                if (cut.x > r.x)
                    found.push_back(make_piece(r.x, y_top[COORD_BITS-1:0], cut.x - r.x,
                                               t_coord'(y_bot - y_top), SIDE_LEFT));
                if (r_right > c_right)
                    found.push_back(make_piece(c_right[COORD_BITS-1:0], y_top[COORD_BITS-1:0],
                                               t_coord'(r_right - c_right),
                                               t_coord'(y_bot - y_top), SIDE_RIGHT));
            end
        end
        foreach (found[i]) begin
            p      = found[i];
            p.last = (i == found.size() - 1);
            pending_pieces.push_back(p);
        end
    endfunction

    function automatic void note_mismatch(input string what, input t_piece want,
                                          input t_piece got);
        string want_s;
        string got_s;
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            want_s = $sformatf("x=%0d y=%0d w=%0d h=%0d side=%0d last=%0b",
                               want.x, want.y, want.w, want.h, want.side, want.last);
            got_s  = $sformatf("x=%0d y=%0d w=%0d h=%0d side=%0d last=%0b",
                               got.x, got.y, got.w, got.h, got.side, got.last);
            $display("%s: expected %s, got %s", what, want_s, got_s);
        end
    endfunction

    always @(posedge i_clk) begin
        t_piece got, want;
        if (i_rst_n === 1'b1 && piece_if.valid === 1'b1 && piece_if.ready === 1'b1) begin
            got.x    = piece_if.piece_x;
            got.y    = piece_if.piece_y;
            got.w    = piece_if.piece_width;
            got.h    = piece_if.piece_height;
            got.side = piece_if.piece_side;
            got.last = piece_if.last_piece;
            if (pending_pieces.size() == 0) begin
                note_mismatch("unexpected piece", '0, got);
            end else begin
                want = pending_pieces.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
                    got.h !== want.h || got.side !== want.side || got.last !== want.last)
                    note_mismatch("piece mismatch", want, got);
            end
        end
    end

    initial begin : piece_sink
        int n;
        piece_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                n           = hold_cycles;
                hold_cycles = 0;
                holding     = 1'b1;
                piece_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                holding = 1'b0;
            end else begin
                n = gap_len(rx_stalls_on);
                piece_if.ready <= (n == 0);
                repeat ((n == 0) ? $urandom_range(1, 6) : n) @(posedge i_clk);
            end
        end
    end

    task automatic send_box(input t_coord x, input t_coord y, input t_coord w, input t_coord h);
        int   gap;
        t_box r;
        gap = gap_len(tx_gaps_on);
        if (gap > 0) begin
            rect_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rect_if.valid       <= 1'b1;
        rect_if.rect_x      <= x;
        rect_if.rect_y      <= y;
        rect_if.rect_width  <= w;
        rect_if.rect_height <= h;
        do @(posedge i_clk); while (rect_if.ready !== 1'b1);
        r.x = x;
        r.y = y;
        r.w = w;
        r.h = h;
        subtract_cut(r);
    endtask

    // Write all four cut registers; only while nothing is in flight
    task automatic set_cut(input t_coord x, input t_coord y, input t_coord w, input t_coord h);
        t_cfg_reg idx;
        t_coord   val;
        for (int i = 0; i < 4; i++) begin
            idx = t_cfg_reg'(i);
            case (idx)
                REG_CUT_X:      val = x;
                REG_CUT_Y:      val = y;
                REG_CUT_WIDTH:  val = w;
                REG_CUT_HEIGHT: val = h;
                default:        val = '0;
            endcase
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx;
            cfg_if.data  <= val;
            do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        end
        cfg_if.valid <= 1'b0;
        cut.x = x;
        cut.y = y;
        cut.w = w;
        cut.h = h;
    endtask

    task automatic settle_idle();
        int waited;
        waited = 0;
        rect_if.valid <= 1'b0;
        while (pending_pieces.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_cut();
        send_box(16'd0, 16'd0, 16'd0, 16'd0);
        send_box(16'd5, 16'd5, 16'd3, 16'd3);
        send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        settle_idle();
    endtask

    task automatic test_sides();
        set_cut(16'd100, 16'd100, 16'd50, 16'd50);
        send_box(16'd110, 16'd110, 16'd10, 16'd10);
        send_box(16'd100, 16'd100, 16'd50, 16'd50);
        send_box(16'd0, 16'd0, 16'd10, 16'd10);
        send_box(16'd50, 16'd100, 16'd50, 16'd50);
        send_box(16'd90, 16'd80, 16'd80, 16'd90);
        send_box(16'd100, 16'd90, 16'd50, 16'd20);
        send_box(16'd100, 16'd140, 16'd50, 16'd20);
        send_box(16'd90, 16'd100, 16'd20, 16'd50);
        send_box(16'd140, 16'd100, 16'd20, 16'd50);
        settle_idle();
    endtask

    task automatic test_wrap_and_extremes();
        set_cut(16'd60000, 16'd60000, 16'd10000, 16'd10000);
        send_box(16'd50000, 16'd50000, 16'd30000, 16'd30000);
        settle_idle();
        set_cut(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_box(16'd65000, 16'd65000, 16'hFFFF, 16'hFFFF);
        send_box(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        settle_idle();
    endtask

    task automatic test_empty_rects();
        set_cut(16'd100, 16'd100, 16'd0, 16'd50);
        send_box(16'd90, 16'd110, 16'd20, 16'd5);
        send_box(16'd100, 16'd100, 16'd0, 16'd0);
        settle_idle();
        set_cut(16'd100, 16'd100, 16'd50, 16'd50);
        send_box(16'd120, 16'd90, 16'd0, 16'd30);
        send_box(16'd120, 16'd120, 16'd0, 16'd0);
        settle_idle();
    endtask

    task automatic test_backpressure();
        set_cut(16'd1000, 16'd1000, 16'd100, 16'd100);
        tx_gaps_on  = 1'b0;
        hold_cycles = HOLD_CYCLES;
        while (!holding) @(posedge i_clk);
        for (int n = 0; n < 24; n++)
            send_box(t_coord'(900 + n), 16'd950, 16'd300, 16'd200);
        settle_idle();
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random();
        int     roll;
        t_coord x, y, w, h;
        for (int ph = 0; ph < 7; ph++) begin
            tx_gaps_on   = (ph != 2);
            rx_stalls_on = (ph != 2);
            case (ph)
                1: set_cut(t_coord'($urandom_range(0, 65535)), t_coord'($urandom_range(0, 65535)),
                           t_coord'($urandom_range(0, 65535)), t_coord'($urandom_range(0, 65535)));
                3: set_cut(t_coord'($urandom_range(65000, 65535)),
                           t_coord'($urandom_range(65000, 65535)),
                           t_coord'($urandom_range(0, 65535)), t_coord'($urandom_range(0, 65535)));
                4: set_cut(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                5: set_cut(t_coord'($urandom_range(0, 500)), t_coord'($urandom_range(0, 500)),
                           $urandom_range(0, 1) ? 16'd0 : t_coord'($urandom_range(1, 200)),
                           $urandom_range(0, 1) ? 16'd0 : t_coord'($urandom_range(1, 200)));
                6: set_cut(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
                default: set_cut(t_coord'($urandom_range(0, 300)), t_coord'($urandom_range(0, 300)),
                                 t_coord'($urandom_range(1, 200)), t_coord'($urandom_range(1, 200)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && ph % 2 == 1) begin
                    rect_if.valid <= 1'b0;
                    do @(posedge i_clk); while (pending_pieces.size() != 0);
                end
                roll = $urandom_range(0, 9);
                if (roll < 2) begin
                    x = t_coord'($urandom_range(0, 65535));
                    y = t_coord'($urandom_range(0, 65535));
                    w = t_coord'($urandom_range(0, 65535));
                    h = t_coord'($urandom_range(0, 65535));
                end else begin
                    x = near(cut.x, cut.w);
                    y = near(cut.y, cut.h);
                    w = t_coord'($urandom_range(0, cut.w + 96));
                    h = t_coord'($urandom_range(0, cut.h + 96));
                    if (roll == 2) begin
                        if ($urandom_range(0, 1)) w = '0;
                        else h = '0;
                    end
                end
                send_box(x, y, w, h);
            end
            settle_idle();
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        rect_if.valid       <= 1'b0;
        rect_if.rect_x      <= '0;
        rect_if.rect_y      <= '0;
        rect_if.rect_width  <= '0;
        rect_if.rect_height <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= REG_CUT_X;
        cfg_if.data         <= '0;
        cut                  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_cut();
        test_sides();
        test_wrap_and_extremes();
        test_empty_rects();
        test_backpressure();
        test_random();
        settle_idle();
        if (mismatch_count == 0 && pending_pieces.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== rectangle_subtract.f =====
design/rs_pkg.sv
design/rs_if.sv
design/rs_serial.sv
design/rectangle_subtract.sv
design/rs_checker.sv
tb/tb_top.sv
